// ----- design/groc_pkg.sv -----
// Shared types and constants for the grid ray occlusion test block.
package groc_pkg;

	// Configuration register indexes
	localparam logic [1:0] REG_LEVEL_WIDTH  = 2'd0;
	localparam logic [1:0] REG_LEVEL_HEIGHT = 2'd1;
	localparam logic [1:0] REG_TILE_SIZE    = 2'd2;

	// Request types
	localparam logic REQ_WRITE = 1'b0;
	localparam logic REQ_QUERY = 1'b1;

	// Start cell divider: 14 quotient bits, one per cycle
	localparam int unsigned DIV_STEPS = 14;
	localparam int unsigned DIV_CNT_W = 4;

	// Controller to datapath commands
	typedef struct packed {
		logic capture;
		logic wr;
		logic clr;
		logic load;
		logic div;
		logic fix;
		logic mul;
		logic diff;
		logic walk;
		logic drain;
	} cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic zero_len;
		logic walk_end;
		logic hit;
		logic clear_done;
	} sts_t;

endpackage

// ----- design/grid_ray_occlusion_test.sv -----
// Top level: configuration registers, controller and datapath.
//
//  channel | direction | handshake             | payload
//  in      | input     | in_valid / in_stall   | req_type, cell_col, cell_row, cell_blocks,
//          |           |                       | from_x, from_y, to_x, to_y
//  out     | output    | out_valid / out_stall | blocked
//  cfg     | input     | cfg_we                | cfg_index, cfg_data
//
// A cell write is done in the cycle it is accepted. A query, from its
// accepting cycle, steps through setup, the bit-serial start cell divider,
// the fix, multiply and difference setup steps for the crossing products,
// the walk over the block map read port, a drain of the last read and the
// result state, held while out_stall is high. A blocking cell ends the walk
// early; a zero-length segment goes from setup straight to the result. One
// item is in flight at a time.
// After reset all MAX_COLS * MAX_ROWS cells of the block map are cleared at
// one cell a cycle, with in_stall high; configuration writes are taken.
module grid_ray_occlusion_test #(
	parameter int MAX_COLS = 256,
	parameter int MAX_ROWS = 256
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               req_type,
	input  logic [7:0]         cell_col,
	input  logic [7:0]         cell_row,
	input  logic               cell_blocks,
	input  logic signed [22:0] from_x,
	input  logic signed [22:0] from_y,
	input  logic signed [22:0] to_x,
	input  logic signed [22:0] to_y,
	output logic               out_valid,
	input  logic               out_stall,
	output logic               blocked,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_index,
	input  logic [8:0]         cfg_data
);

	logic [8:0] level_width_q, level_height_q;
	logic [6:0] tile_size_q;
	groc_pkg::cmd_t cmd;
	groc_pkg::sts_t sts;

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_width_q <= 9'd256;
			level_height_q <= 9'd256;
			tile_size_q <= 7'd16;
		end else if (cfg_we) begin
			case (cfg_index)
				groc_pkg::REG_LEVEL_WIDTH:  level_width_q <= cfg_data;
				groc_pkg::REG_LEVEL_HEIGHT: level_height_q <= cfg_data;
				groc_pkg::REG_TILE_SIZE:    tile_size_q <= cfg_data[6:0];
				default: ;
			endcase
		end
	end

	groc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.req_type  (req_type),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	groc_dpath #(
		.MAX_COLS (MAX_COLS),
		.MAX_ROWS (MAX_ROWS)
	) u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.level_width  (level_width_q),
		.level_height (level_height_q),
		.tile_size    (tile_size_q),
		.cell_col     (cell_col),
		.cell_row     (cell_row),
		.cell_blocks  (cell_blocks),
		.from_x       (from_x),
		.from_y       (from_y),
		.to_x         (to_x),
		.to_y         (to_y),
		.blocked      (blocked)
	);

endmodule

// ----- design/groc_dpath.sv -----
// Datapath: block map memory, start cell divider and DDA stepping registers.
module groc_dpath #(
	parameter int MAX_COLS = 256,
	parameter int MAX_ROWS = 256
) (
	input  logic               clk,
	input  logic               arst_n,
	input  groc_pkg::cmd_t     cmd,
	output groc_pkg::sts_t     sts,
	input  logic [8:0]         level_width,
	input  logic [8:0]         level_height,
	input  logic [6:0]         tile_size,
	input  logic [7:0]         cell_col,
	input  logic [7:0]         cell_row,
	input  logic               cell_blocks,
	input  logic signed [22:0] from_x,
	input  logic signed [22:0] from_y,
	input  logic signed [22:0] to_x,
	input  logic signed [22:0] to_y,
	output logic               blocked
);

	localparam int DEPTH = MAX_COLS * MAX_ROWS;
	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(MAX_COLS);
	localparam int RW = $clog2(MAX_ROWS);

	// Captured query
	logic [22:0] x0_q, y0_q, x1_q, y1_q;
	// Setup and divider
	logic [23:0] adx_q, ady_q;
	logic        negx_q, negy_q, sgx_q, sgy_q;
	logic [13:0] dqx_q, dqy_q;
	logic [6:0]  remx_q, remy_q;
	// Walk
	logic signed [17:0] cx_q, cy_q;
	logic [24:0] ex_q, ey_q;
	logic [38:0] wady_q, wadx_q;
	logic [39:0] pa_q, pb_q;
	logic signed [50:0] p_q;
	// Memory read
	logic          pend_q, inlvl_q, rd_q, res_q;
	logic [AW-1:0] clr_cnt_q;
	logic          mem [DEPTH];

	logic [6:0]  t;
	logic [14:0] w;
	logic [23:0] dx, dy;
	logic [7:0]  divx, divy;
	logic [6:0]  rx, ry;
	logic [14:0] rrx, rry;
	logic        stepx;
	logic [17:0] wlim, hlim;
	logic        in_lvl;
	logic [AW-1:0] raddr, waddr;
	logic        we, wdata, wr_ok;

	// One restoring division step: {quotient bit, remainder}
	function automatic logic [7:0] div_step(input logic [6:0] rem, input logic b,
		input logic [6:0] d);
		logic [7:0] tmp;
		tmp = {rem, b};
		if (tmp >= {1'b0, d})
			div_step = {1'b1, 7'(tmp - {1'b0, d})};
		else
			div_step = {1'b0, tmp[6:0]};
	endfunction

	// Tile edge, zero acts as one
	always_comb begin
		t = (tile_size == 7'd0) ? 7'd1 : tile_size;
		w = {t, 8'b0};
		dx = {x1_q[22], x1_q} - {x0_q[22], x0_q};
		dy = {y1_q[22], y1_q} - {y0_q[22], y0_q};
		divx = div_step(remx_q, dqx_q[13], t);
		divy = div_step(remy_q, dqy_q[13], t);
		rx = sgx_q ? 7'(t - 7'd1 - remx_q) : remx_q;
		ry = sgy_q ? 7'(t - 7'd1 - remy_q) : remy_q;
		rrx = {rx, x0_q[7:0]};
		rry = {ry, y0_q[7:0]};
		stepx = p_q[50];
	end

	// Level bounds clamped to the store
	always_comb begin
		wlim = ({9'b0, level_width} > 18'(MAX_COLS)) ? 18'(MAX_COLS) : {9'b0, level_width};
		hlim = ({9'b0, level_height} > 18'(MAX_ROWS)) ? 18'(MAX_ROWS) : {9'b0, level_height};
		in_lvl = !cx_q[17] && !cy_q[17] && ($unsigned(cx_q) < wlim) && ($unsigned(cy_q) < hlim);
		raddr = AW'(AW'(cy_q[RW-1:0]) * AW'(MAX_ROWS > 0 ? MAX_COLS : 1)) + AW'(cx_q[CW-1:0]);
		wr_ok = ({5'b0, cell_col} < 13'(MAX_COLS)) && ({5'b0, cell_row} < 13'(MAX_ROWS));
		we = cmd.clr || (cmd.wr && wr_ok);
		wdata = cmd.clr ? 1'b0 : cell_blocks;
		waddr = cmd.clr ? clr_cnt_q
			: AW'(AW'(cell_row) * AW'(MAX_COLS)) + AW'(cell_col);
	end

	// Status toward the controller
	always_comb begin
		sts.zero_len = (x0_q == x1_q) && (y0_q == y1_q);
		sts.walk_end = stepx ? (ex_q >= {1'b0, adx_q}) : (ey_q >= {1'b0, ady_q});
		sts.hit = pend_q && inlvl_q && rd_q;
		sts.clear_done = (clr_cnt_q == AW'(DEPTH - 1));
	end

	// Block map: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rd_q <= mem[raddr];
		inlvl_q <= in_lvl;
	end

	// Capture, divide, set up and step the traversal
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			x0_q <= from_x;
			y0_q <= from_y;
			x1_q <= to_x;
			y1_q <= to_y;
		end
		if (cmd.load) begin
			adx_q <= dx[23] ? 24'(-dx) : dx;
			ady_q <= dy[23] ? 24'(-dy) : dy;
			negx_q <= dx[23];
			negy_q <= dy[23];
			sgx_q <= x0_q[22];
			sgy_q <= y0_q[22];
			dqx_q <= x0_q[22] ? ~x0_q[21:8] : x0_q[21:8];
			dqy_q <= y0_q[22] ? ~y0_q[21:8] : y0_q[21:8];
			remx_q <= 7'd0;
			remy_q <= 7'd0;
		end
		if (cmd.div) begin
			dqx_q <= {dqx_q[12:0], divx[7]};
			dqy_q <= {dqy_q[12:0], divy[7]};
			remx_q <= divx[6:0];
			remy_q <= divy[6:0];
		end
		if (cmd.fix) begin
			cx_q <= sgx_q ? ~{4'b0, dqx_q} : {4'b0, dqx_q};
			cy_q <= sgy_q ? ~{4'b0, dqy_q} : {4'b0, dqy_q};
			ex_q <= negx_q ? {10'b0, rrx} : {10'b0, 15'(w - rrx)};
			ey_q <= negy_q ? {10'b0, rry} : {10'b0, 15'(w - rry)};
			wady_q <= 39'(w) * 39'(ady_q);
			wadx_q <= 39'(w) * 39'(adx_q);
		end
		if (cmd.mul) begin
			pa_q <= 40'(ex_q[15:0]) * 40'(ady_q);
			pb_q <= 40'(ey_q[15:0]) * 40'(adx_q);
		end
		if (cmd.diff)
			p_q <= $signed({11'b0, pa_q}) - $signed({11'b0, pb_q});
		// Advance along the axis with the nearer crossing, y on a tie
		if (cmd.walk) begin
			if (stepx) begin
				cx_q <= negx_q ? cx_q - 18'sd1 : cx_q + 18'sd1;
				ex_q <= ex_q + {10'b0, w};
				p_q <= p_q + $signed({12'b0, wady_q});
			end else begin
				cy_q <= negy_q ? cy_q - 18'sd1 : cy_q + 18'sd1;
				ey_q <= ey_q + {10'b0, w};
				p_q <= p_q - $signed({12'b0, wadx_q});
			end
		end
	end

	// Control registers: pending read, result, clear sweep
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= 1'b0;
			res_q <= 1'b0;
			clr_cnt_q <= '0;
		end else begin
			pend_q <= cmd.walk;
			if (cmd.load)
				res_q <= 1'b0;
			else if ((cmd.walk || cmd.drain) && sts.hit)
				res_q <= 1'b1;
			if (cmd.clr)
				clr_cnt_q <= clr_cnt_q + AW'(1);
		end
	end

	assign blocked = res_q;

endmodule

// ----- design/groc_ctrl.sv -----
// Controller: sequences clearing, writes and segment query steps.
module groc_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_stall,
	input  logic           req_type,
	output logic           out_valid,
	input  logic           out_stall,
	input  groc_pkg::sts_t sts,
	output groc_pkg::cmd_t cmd
);

	typedef enum logic [9:0] {
		ST_CLEAR = 10'b0000000001,
		ST_IDLE  = 10'b0000000010,
		ST_SETUP = 10'b0000000100,
		ST_DIV   = 10'b0000001000,
		ST_FIX   = 10'b0000010000,
		ST_MUL   = 10'b0000100000,
		ST_DIFF  = 10'b0001000000,
		ST_WALK  = 10'b0010000000,
		ST_DRAIN = 10'b0100000000,
		ST_OUT   = 10'b1000000000
	} state_t;

	state_t state_q, state_d;
	logic [groc_pkg::DIV_CNT_W-1:0] cnt_q;

	// Commands per state
	always_comb begin
		cmd = '0;
		cmd.clr = (state_q == ST_CLEAR);
		cmd.wr = (state_q == ST_IDLE) && in_valid && (req_type == groc_pkg::REQ_WRITE);
		cmd.capture = (state_q == ST_IDLE) && in_valid && (req_type == groc_pkg::REQ_QUERY);
		cmd.load = (state_q == ST_SETUP);
		cmd.div = (state_q == ST_DIV);
		cmd.fix = (state_q == ST_FIX);
		cmd.mul = (state_q == ST_MUL);
		cmd.diff = (state_q == ST_DIFF);
		cmd.walk = (state_q == ST_WALK);
		cmd.drain = (state_q == ST_DRAIN);
		in_stall = (state_q != ST_IDLE);
		out_valid = (state_q == ST_OUT);
	end

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: if (sts.clear_done) state_d = ST_IDLE;
			ST_IDLE:  if (cmd.capture) state_d = ST_SETUP;
			ST_SETUP: state_d = sts.zero_len ? ST_OUT : ST_DIV;
			ST_DIV: begin
				if (cnt_q == groc_pkg::DIV_CNT_W'(groc_pkg::DIV_STEPS - 1))
					state_d = ST_FIX;
			end
			ST_FIX:   state_d = ST_MUL;
			ST_MUL:   state_d = ST_DIFF;
			ST_DIFF:  state_d = ST_WALK;
			ST_WALK: begin
				if (sts.hit)
					state_d = ST_OUT;
				else if (sts.walk_end)
					state_d = ST_DRAIN;
			end
			ST_DRAIN: state_d = ST_OUT;
			ST_OUT:   if (!out_stall) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	// Hold state and divider count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			cnt_q <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_DIV)
				cnt_q <= cnt_q + groc_pkg::DIV_CNT_W'(1);
			else
				cnt_q <= '0;
		end
	end

endmodule
